@@ hdl/rpis_pkg.sv @@
`timescale 1ns / 1ps
package rpis_pkg;

  localparam int MAX_PATHS = 16;
  localparam int NODES     = 32;

  localparam int SLOT_W    = $clog2(MAX_PATHS);
  localparam int NODE_W    = $clog2(NODES);
  localparam int PRED_W    = 6;
  localparam int DEPTH_W   = $clog2(NODES + 1);
  localparam int CNT_W     = $clog2(MAX_PATHS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_DEST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;

  typedef struct packed {
    logic route_we;
    logic cnt_clr;
    logic cnt_one;
    logic cnt_inc;
    logic walk_start;
    logic walk_step;
    logic walk_end;
    logic key_load;
    logic cmp_load;
    logic cmp_step;
    logic shift;
    logic place;
    logic emit;
  } rpis_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic last_idx;
    logic route_valid;
    logic d_full;
    logic cmp_done;
    logic cmp_after;
    logic j_one;
    logic out_free;
  } rpis_stat_t;

endpackage

@@ hdl/rpis_if.sv @@
`timescale 1ns / 1ps
interface rpis_in_if;
  logic                          valid;
  logic                          ready;
  logic [rpis_pkg::SLOT_W-1:0]   path_slot;
  logic [rpis_pkg::NODE_W-1:0]   node_index;
  logic signed [rpis_pkg::PRED_W-1:0] predecessor;
  logic                          last_entry;

  modport source (output valid, path_slot, node_index, predecessor, last_entry,
                  input ready);
  modport sink (input valid, path_slot, node_index, predecessor, last_entry,
                output ready);
endinterface

interface rpis_out_if;
  logic                        valid;
  logic                        ready;
  logic [rpis_pkg::SLOT_W-1:0] sorted_slot;
  logic                        chain_overflow;
  logic                        last_path;

  modport source (output valid, sorted_slot, chain_overflow, last_path, input ready);
  modport sink (input valid, sorted_slot, chain_overflow, last_path, output ready);
endinterface

@@ hdl/route_path_insertion_sort_top.sv @@
`timescale 1ns / 1ps
// Route path ordering block.
// Input channel in_ch: one beat loads one predecessor entry (slot, node,
// predecessor, -1 for none) into the route table. A beat with last_entry set
// also starts a sort run, unless path_count is 0, over the first path_count
// slots (at most 16) of the slot order.
// Output channel out_ch: one beat per slot in use, in lexicographic order of
// the node sequences, last_path marking the final beat of a run.
// Configuration: cfg_we/cfg_index/cfg_data; index 0 destination_node,
// index 1 path_count. Write only while the block is idle.
// Operation: a plain entry is written to the route table when accepted. A
// sort run walks each slot's chain of nodes through the route table read
// port, then insertion-sorts the slots, comparing node sequences through the
// dual read port of the walk memory; then it emits one result beat per cycle
// while out_ch.ready is high. No entry is accepted during a run.
// Reset: slot order returns to identity, destination_node 0, path_count 1;
// route table contents are undefined until written.
// Receiver stall: the result register holds its beat and the run pauses
// until out_ch.ready is high.
module route_path_insertion_sort_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rpis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpis_pkg::CFG_W-1:0]     cfg_data,
  rpis_in_if.sink                        in_ch,
  rpis_out_if.source                     out_ch
);
  import rpis_pkg::*;

  rpis_cmd_t  cmd;
  rpis_stat_t stat;

  // sequence load, walk, sort and emit
  rpis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_entry),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables, walk memory, slot order and result register
  rpis_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_slot   (in_ch.path_slot),
    .in_node   (in_ch.node_index),
    .in_pred   (in_ch.predecessor),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_slot  (out_ch.sorted_slot),
    .out_ovf   (out_ch.chain_overflow),
    .out_last  (out_ch.last_path)
  );

endmodule

@@ hdl/rpis_dpath.sv @@
`timescale 1ns / 1ps
module rpis_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rpis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpis_pkg::CFG_W-1:0]       cfg_data,
  input  logic [rpis_pkg::SLOT_W-1:0]      in_slot,
  input  logic [rpis_pkg::NODE_W-1:0]      in_node,
  input  logic signed [rpis_pkg::PRED_W-1:0] in_pred,
  input  rpis_pkg::rpis_cmd_t              cmd,
  output rpis_pkg::rpis_stat_t             stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rpis_pkg::SLOT_W-1:0]      out_slot,
  output logic                             out_ovf,
  output logic                             out_last
);
  import rpis_pkg::*;

  localparam int ROUTE_DEPTH = MAX_PATHS * NODES;
  localparam int WALK_DEPTH  = MAX_PATHS * (2 ** DEPTH_W);

  logic [NODE_W-1:0]  dest;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   n;
  logic [SLOT_W-1:0]  last_i;

  logic [PRED_W-1:0]  route_mem [ROUTE_DEPTH];
  logic [PRED_W-1:0]  route_q;
  logic [NODE_W-1:0]  walk_mem [WALK_DEPTH];
  logic [NODE_W-1:0]  na_q;
  logic [NODE_W-1:0]  nb_q;

  logic [NODE_W-1:0]  cur;
  logic [DEPTH_W-1:0] d;
  logic [SLOT_W-1:0]  wslot;
  logic [SLOT_W-1:0]  i;
  logic [SLOT_W-1:0]  j;
  logic [SLOT_W-1:0]  key;
  logic [DEPTH_W-1:0] lk;
  logic [SLOT_W-1:0]  ca;
  logic [DEPTH_W-1:0] la;
  logic [DEPTH_W-1:0] ci;
  logic [DEPTH_W-1:0] len [MAX_PATHS];
  logic [MAX_PATHS-1:0] cut;
  logic [SLOT_W-1:0]  order [MAX_PATHS];

  logic [SLOT_W-1:0]  ord_idx;
  logic [SLOT_W-1:0]  ord_rd;
  logic [DEPTH_W-1:0] m;
  logic               walk_we;
  logic [SLOT_W+DEPTH_W-1:0] walk_wa;
  logic [NODE_W-1:0]  walk_wd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dest  <= '0;
      count <= CNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEST:  dest  <= cfg_data[NODE_W-1:0];
        REG_COUNT: count <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n      = (count > CNT_W'(MAX_PATHS)) ? CNT_W'(MAX_PATHS) : count;
  assign last_i = SLOT_W'(n - CNT_W'(1));

  assign ord_idx = cmd.cmp_load ? SLOT_W'(j - SLOT_W'(1)) : i;
  assign ord_rd  = order[ord_idx];
  assign m       = (la < lk) ? la : lk;

  // predecessor table
  always_ff @(posedge clk) begin
    if (cmd.route_we) begin
      route_mem[{in_slot, in_node}] <= in_pred;
    end
    route_q <= route_mem[{wslot, cur}];
  end

  // walked node sequences, one write port and two read ports
  always_comb begin
    walk_we = cmd.walk_start | cmd.walk_step;
    walk_wa = cmd.walk_start ? {ord_rd, DEPTH_W'(0)} : {wslot, DEPTH_W'(d + DEPTH_W'(1))};
    walk_wd = cmd.walk_start ? dest : route_q[NODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (walk_we) begin
      walk_mem[walk_wa] <= walk_wd;
    end
    na_q <= walk_mem[{ca, DEPTH_W'(la - ci)}];
    nb_q <= walk_mem[{key, DEPTH_W'(lk - ci)}];
  end

  // walk, compare and sort registers
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      i <= '0;
    end else if (cmd.cnt_one) begin
      i <= SLOT_W'(1);
    end else if (cmd.cnt_inc) begin
      i <= SLOT_W'(i + SLOT_W'(1));
    end
    if (cmd.walk_start) begin
      wslot <= ord_rd;
      cur   <= dest;
      d     <= '0;
    end else if (cmd.walk_step) begin
      cur <= route_q[NODE_W-1:0];
      d   <= DEPTH_W'(d + DEPTH_W'(1));
    end
    if (cmd.walk_end) begin
      len[wslot] <= d;
      cut[wslot] <= stat.d_full & stat.route_valid;
    end
    if (cmd.key_load) begin
      key <= ord_rd;
      lk  <= len[ord_rd];
      j   <= i;
    end else if (cmd.shift) begin
      j <= SLOT_W'(j - SLOT_W'(1));
    end
    if (cmd.cmp_load) begin
      ca <= ord_rd;
      la <= len[ord_rd];
      ci <= '0;
    end else if (cmd.cmp_step) begin
      ci <= DEPTH_W'(ci + DEPTH_W'(1));
    end
  end

  // slot order, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PATHS; k++) begin
        order[k] <= SLOT_W'(k);
      end
    end else if (cmd.shift) begin
      order[j] <= ca;
    end else if (cmd.place) begin
      order[j] <= key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_slot <= ord_rd;
      out_ovf  <= cut[ord_rd];
      out_last <= (i == last_i);
    end
  end

  always_comb begin
    stat.n_zero      = (n == '0);
    stat.n_one       = (n == CNT_W'(1));
    stat.last_idx    = (i == last_i);
    stat.route_valid = ~route_q[PRED_W-1];
    stat.d_full      = (d == DEPTH_W'(NODES));
    stat.cmp_done    = (ci == m) || (na_q != nb_q);
    stat.cmp_after   = (ci == m) ? (la > lk) : (na_q > nb_q);
    stat.j_one       = (j == SLOT_W'(1));
    stat.out_free    = ~out_valid | out_ready;
  end

  a_shift_j: assert property (@(posedge clk) disable iff (rst) cmd.shift |-> j != '0)
    else $error("shift below position zero");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> d < DEPTH_W'(NODES))
    else $error("walk stepped past node limit");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

@@ hdl/rpis_ctrl.sv @@
`timescale 1ns / 1ps
module rpis_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  input  rpis_pkg::rpis_stat_t stat,
  output rpis_pkg::rpis_cmd_t  cmd
);
  import rpis_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WSTART, ST_WWAIT, ST_WCHK, ST_KEY,
    ST_CLOAD, ST_CWAIT, ST_CCHK, ST_PLACE, ST_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.route_we = in_valid;
        if (in_valid && in_last && !stat.n_zero) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_WSTART;
        end
      end
      ST_WSTART: begin
        cmd.walk_start = 1'b1;
        state_next     = ST_WWAIT;
      end
      ST_WWAIT: state_next = ST_WCHK;
      ST_WCHK: begin
        if (stat.route_valid && !stat.d_full) begin
          cmd.walk_step = 1'b1;
          state_next    = ST_WWAIT;
        end else begin
          cmd.walk_end = 1'b1;
          if (stat.last_idx && stat.n_one) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_EMIT;
          end else if (stat.last_idx) begin
            cmd.cnt_one = 1'b1;
            state_next  = ST_KEY;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = ST_WSTART;
          end
        end
      end
      ST_KEY: begin
        cmd.key_load = 1'b1;
        state_next   = ST_CLOAD;
      end
      ST_CLOAD: begin
        cmd.cmp_load = 1'b1;
        state_next   = ST_CWAIT;
      end
      ST_CWAIT: state_next = ST_CCHK;
      ST_CCHK: begin
        if (!stat.cmp_done) begin
          cmd.cmp_step = 1'b1;
          state_next   = ST_CWAIT;
        end else if (stat.cmp_after) begin
          cmd.shift  = 1'b1;
          state_next = stat.j_one ? ST_PLACE : ST_CLOAD;
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        if (stat.last_idx) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = ST_KEY;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_idx) begin
            state_next = ST_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
